>>> rtl/core/rmsdb_pkg.sv
// Package for the RMS level meter: payload types and fixed constants.
// Depends on nothing; every other file of the block uses it.
package rmsdb_pkg;

  localparam int SampleW = 24;
  localparam int LevelW  = 16;
  localparam int TotalW  = 13;
  localparam int SumW    = 58;

  // Samples past this count in one frame are dropped.
  localparam int FrameMax = 4096;

  localparam logic [31:0] DbScaleQ16 = 32'd50504453;
  localparam logic signed [LevelW-1:0] FloorThresh = -16'sd20480;
  localparam logic signed [LevelW-1:0] FloorLevel  = -16'sd24576;

  // One finished frame handed from the front part to the back part.
  typedef struct packed {
    logic [SumW-1:0]   sum;
    logic [TotalW-1:0] cnt;
  } frame_t;

  typedef struct packed {
    logic signed [LevelW-1:0] level_db;
    logic                     no_data;
    logic [TotalW-1:0]        sample_total;
  } result_t;

endpackage

>>> rtl/core/rmsdb_if.sv
// Valid/ready channel interfaces for the meter's input and result streams.
// Depends on rmsdb_pkg for the field widths.
interface rmsdb_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rmsdb_pkg::SampleW-1:0] sample;
  logic                                 has_sample;
  logic                                 last;
  modport source (output valid, sample, has_sample, last, input ready);
  modport sink (input valid, sample, has_sample, last, output ready);
endinterface

interface rmsdb_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rmsdb_pkg::LevelW-1:0] level_db;
  logic                                no_data;
  logic [rmsdb_pkg::TotalW-1:0]        sample_total;
  modport source (output valid, level_db, no_data, sample_total, input ready);
  modport sink (input valid, level_db, no_data, sample_total, output ready);
endinterface

>>> rtl/core/rmsdb_front.sv
// Front part: squares and accumulates samples, closes a frame on last.
// Depends on rmsdb_pkg; pushes finished frames into the frame queue.
module rmsdb_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [rmsdb_pkg::SampleW-1:0] in_sample,
  input  logic                                 in_has_sample,
  input  logic                                 in_last,
  output logic                                 push,
  output rmsdb_pkg::frame_t                    push_frame,
  input  logic                                 q_full
);
  localparam int CntW = $clog2(rmsdb_pkg::FrameMax + 1);

  logic [rmsdb_pkg::SumW-1:0] sum_r, sum_nxt;
  logic [CntW-1:0]            cnt_r, cnt_nxt;
  logic [47:0]                sq;
  logic [rmsdb_pkg::SumW:0]   add;
  logic                       take;
  logic                       acc;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign acc      = in_has_sample && (cnt_r < CntW'(rmsdb_pkg::FrameMax));

  // Square, then a saturating add into the accumulator.
  always_comb begin
    sq      = 48'($signed(in_sample) * $signed(in_sample));
    add     = {1'b0, sum_r} + {{(rmsdb_pkg::SumW-47){1'b0}}, sq};
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (acc) begin
      sum_nxt = add[rmsdb_pkg::SumW] ? '1 : add[rmsdb_pkg::SumW-1:0];
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  assign push            = take && in_last;
  assign push_frame.sum  = sum_nxt;
  assign push_frame.cnt  = rmsdb_pkg::TotalW'(cnt_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (take) begin
      sum_r <= in_last ? '0 : sum_nxt;
      cnt_r <= in_last ? '0 : cnt_nxt;
    end
  end
endmodule

>>> rtl/core/rmsdb_queue.sv
// Two-entry frame queue between the front and back parts.
// Depends on rmsdb_pkg for the frame type.
module rmsdb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rmsdb_pkg::frame_t push_frame,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output rmsdb_pkg::frame_t head
);
  rmsdb_pkg::frame_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] n_r;

  assign full  = (n_r == 2'd2);
  assign empty = (n_r == 2'd0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_frame;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      n_r  <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      n_r <= n_r + 2'(push) - 2'(pop);
    end
  end
endmodule

>>> rtl/core/rmsdb_back.sv
// Back part: sequential log2 of sum and count, dB scaling and the floor.
// Depends on rmsdb_pkg; pops frames from the queue, drives the result.
module rmsdb_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  input  rmsdb_pkg::frame_t        q_head,
  output logic                     pop,
  output logic                     res_valid,
  input  logic                     res_ready,
  output rmsdb_pkg::result_t       res
);
  typedef enum logic [2:0] {
    S_IDLE, S_NORM, S_SQR, S_NEXT, S_MUL, S_OUT
  } state_t;

  state_t      state_r;
  logic [57:0] x_r;
  logic [12:0] cnt_r;
  logic [5:0]  e_r;
  logic [32:0] m_r;
  logic [4:0]  i_r;
  logic [15:0] frac_r;
  logic [63:0] sq_r;
  logic        second_r;
  logic signed [23:0] lsum_r;
  logic [31:0] mag_in_r;
  logic [63:0] prod_r;
  logic        busy_r;

  logic [5:0]  msb;
  logic [64:0] msq;
  logic [32:0] mnew;
  logic signed [23:0] lq;
  logic signed [24:0] lfin;
  logic [32:0] mag;
  logic signed [rmsdb_pkg::LevelW-1:0] lev;

  // Leading-one position of the operand being taken apart.
  always_comb begin
    msb = '0;
    for (int k = 0; k < 58; k++) if (x_r[k]) msb = 6'(k);
  end

  always_comb begin
    msq  = {1'b0, sq_r} >> 31;
    mnew = msq[32] ? msq[33:1] : msq[32:0];
    lq   = {2'b0, e_r, frac_r};
    lfin = 25'(lsum_r) - 25'(lq) - 25'sd3014656;
    mag  = 33'((prod_r + 64'h8000_0000) >> 32);
    if (mag > 33'd32768) lev = -16'sd32768;
    else                 lev = -16'(mag);
  end

  assign pop       = (state_r == S_IDLE) && !q_empty && !busy_r;
  assign res_valid = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      if (busy_r && res_ready) busy_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (pop) begin
          res.sample_total <= q_head.cnt;
          cnt_r    <= q_head.cnt;
          x_r      <= q_head.sum;
          second_r <= 1'b0;
          if (q_head.cnt == '0) begin
            res.level_db <= '0;
            res.no_data  <= 1'b1;
            state_r <= S_OUT;
          end else if (q_head.sum == '0) begin
            res.level_db <= rmsdb_pkg::FloorLevel;
            res.no_data  <= 1'b0;
            state_r <= S_OUT;
          end else begin
            res.no_data <= 1'b0;
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          e_r    <= msb;
          m_r    <= (msb >= 6'd31) ? 33'(x_r >> (msb - 6'd31))
                                   : 33'(x_r << (6'd31 - msb));
          frac_r <= '0;
          i_r    <= '0;
          state_r <= S_SQR;
        end
        S_SQR: begin
          sq_r    <= 64'(m_r[31:0]) * 64'(m_r[31:0]);
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          m_r    <= mnew;
          frac_r <= {frac_r[14:0], msq[32]};
          i_r    <= i_r + 1'b1;
          if (i_r == 5'd15) begin
            if (!second_r) begin
              lsum_r   <= {2'b0, e_r, frac_r[14:0], msq[32]};
              x_r      <= 58'(cnt_r);
              second_r <= 1'b1;
              state_r  <= S_NORM;
            end else begin
              state_r <= S_MUL;
            end
          end else begin
            state_r <= S_SQR;
          end
        end
        // Three steps: latch the magnitude, multiply, then round and floor; a level at or above 0 dB is set to 0.
        S_MUL: begin
          if (lfin >= 0) begin
            res.level_db <= '0;
            state_r <= S_OUT;
          end else begin
            mag_in_r <= 32'(-lfin);
            if (i_r != 5'd31) i_r <= 5'd31;
            else begin
              prod_r  <= 64'(mag_in_r) * 64'(rmsdb_pkg::DbScaleQ16);
              i_r     <= 5'd30;
            end
            if (i_r == 5'd30) begin
              res.level_db <= (lev <= rmsdb_pkg::FloorThresh) ? rmsdb_pkg::FloorLevel
                                                               : lev;
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: if (!busy_r) begin
          busy_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/core/rms_level_meter_db.sv
// Frame RMS level meter in dBFS, 1/256 dB units.
// Samples: one per cycle, accepted while the two-frame queue has room.
// Frame end: the frame closed by the last request passes the queue, two 16-step
// squaring log2 passes, a multiply and one output register; an empty or silent
// frame skips the passes, a 0 dB level the multiply. One frame is worked at a time.
// Reset (rst_n low, synchronous) clears accumulator, count, queue, result valid.
module rms_level_meter_db (
  input logic         clk,
  input logic         rst_n,
  rmsdb_in_if.sink    in_ch,
  rmsdb_out_if.source out_ch
);
  logic              push, q_full, pop, q_empty;
  rmsdb_pkg::frame_t push_frame, head;
  rmsdb_pkg::result_t res;

  rmsdb_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_sample(in_ch.sample), .in_has_sample(in_ch.has_sample),
    .in_last(in_ch.last),
    .push, .push_frame, .q_full
  );

  rmsdb_queue u_queue (
    .clk, .rst_n, .push, .push_frame, .full(q_full),
    .pop, .empty(q_empty), .head
  );

  rmsdb_back u_back (
    .clk, .rst_n, .q_empty, .q_head(head), .pop,
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res
  );

  assign out_ch.level_db     = res.level_db;
  assign out_ch.no_data      = res.no_data;
  assign out_ch.sample_total = res.sample_total;
endmodule
